@@ sv/quadratic_probe_hash_table_unit_macros.svh @@
// Assertion helpers for the hash table unit.
// Each macro expects clk and rst in scope at the point of use.
`ifndef QUADRATIC_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`define QUADRATIC_PROBE_HASH_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, ignored during reset
`define QPHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored during reset
`define QPHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/qpht_pkg.sv @@
`default_nettype none
package qpht_pkg;

  localparam int KEY_W     = 64;
  localparam int SUM_W     = 11;
  localparam int SUM_CNT_W = 4;
  localparam int SLOT_W    = 7;
  localparam int MARK_W    = 2;
  localparam int ENTRY_W   = MARK_W + KEY_W;

  // operation codes
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  // slot marks
  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key_chars;
  } req_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
  } rsp_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_HASH,
    ST_PROBE,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

@@ sv/quadratic_probe_hash_table_unit.sv @@
// Channel   Ports                              Payload
// request   req_valid  req_ready  req          req_item_t  {kind, key_chars}
// response  rsp_valid  rsp_ready  rsp          rsp_item_t  {status, slot}
//
// Per request: ST_SUM forms the byte sum, ST_HASH forms the remainder (reciprocal
//   multiply, back-multiply and subtract, final compare-subtract), then ST_PROBE
//   issues one probe per cycle through the slot memory's registered read port,
//   then ST_DONE loads the response register.
// Unused kind skips straight to the response register.
// After reset a clearing pass empties every slot; req_ready
//   stays low until it ends.
// A held response stalls only the next request's final cycle.
`default_nettype none
`include "quadratic_probe_hash_table_unit_macros.svh"
module quadratic_probe_hash_table_unit
  import qpht_pkg::*;
#(
  parameter int TABLE_SIZE = 127,
  parameter int KEY_BYTES  = 8
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire req_item_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output rsp_item_t      rsp
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam logic [IDX_W:0]   TSIZE_EXT = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SIZE - 1);
  // floor(2^SUM_W / TABLE_SIZE): estimated quotient is low by at most one
  localparam logic [SUM_W-1:0] RECIP     = SUM_W'((2 ** SUM_W) / TABLE_SIZE);
  // quotient is zero whenever the table is wider than the sum, so the low bits do
  localparam logic [SUM_W-1:0] TSIZE_SUM = SUM_W'(TABLE_SIZE);
  localparam logic [SUM_CNT_W-1:0] HASH_LAST_STEP = SUM_CNT_W'(2);

  // keep bytes up to the first zero byte and within KEY_BYTES
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] k;
    logic             alive;
    k     = '0;
    alive = 1'b1;
    for (int b = 0; b < 8; b++) begin
      alive = alive && (b < KEY_BYTES) && (raw[8*b +: 8] != 8'd0);
      if (alive) begin
        k[8*b +: 8] = raw[8*b +: 8];
      end
    end
    return k;
  endfunction

  function automatic logic [SUM_W-1:0] byte_sum(input logic [KEY_W-1:0] k);
    logic [SUM_W-1:0] s;
    s = '0;
    for (int b = 0; b < 8; b++) begin
      s = s + SUM_W'(k[8*b +: 8]);
    end
    return s;
  endfunction

  // fold a value below twice the table size back into range
  function automatic logic [IDX_W-1:0] fold(input logic [IDX_W:0] v);
    logic [IDX_W:0] r;
    r = (v >= TSIZE_EXT) ? (v - TSIZE_EXT) : v;
    return r[IDX_W-1:0];
  endfunction

  state_t state, state_next;

  logic [ENTRY_W-1:0] mem [TABLE_SIZE];
  logic [ENTRY_W-1:0] mem_q;

  logic [1:0]           kind_r;
  logic [KEY_W-1:0]     key_r;
  logic [SUM_W-1:0]     key_sum;
  logic [SUM_W-1:0]     quo;
  logic [SUM_CNT_W-1:0] hash_step;
  logic [IDX_W:0]       rem;
  logic [IDX_W-1:0]     home;
  logic [IDX_W-1:0]     issue_idx;
  logic [IDX_W-1:0]     inc;
  logic                 first;
  logic                 issue_on;
  logic                 pend_v;
  logic [IDX_W-1:0]     pend_idx;
  logic [IDX_W-1:0]     clr_idx;
  logic [1:0]           res_status;
  logic [IDX_W-1:0]     res_idx;

  logic               rd_en;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  logic                 accept;
  logic                 hash_last;
  logic                 issue_go;
  logic [IDX_W:0]       fold_in;
  logic [IDX_W-1:0]     fold_out;
  logic [IDX_W-1:0]     inc_adv;
  logic [2*SUM_W-1:0]   quo_prod;
  logic [2*SUM_W-1:0]   back_prod;
  logic [SUM_W-1:0]     rem_sum;
  logic [MARK_W-1:0]    mark_q;
  logic [KEY_W-1:0]     key_q;
  logic                 ins_take;
  logic                 stop_empty;
  logic                 key_match;
  logic                 exhaust;
  logic                 finish;
  logic                 out_free;

  // probe decision on the entry read last cycle
  always_comb begin
    mark_q     = mem_q[ENTRY_W-1 -: MARK_W];
    key_q      = mem_q[KEY_W-1:0];
    issue_go   = issue_on && (first || (issue_idx != home));
    ins_take   = pend_v && (kind_r == KIND_INSERT) && (mark_q == MARK_EMPTY);
    stop_empty = pend_v && (kind_r != KIND_INSERT) && (mark_q == MARK_EMPTY);
    key_match  = pend_v && (kind_r != KIND_INSERT) && (mark_q == MARK_USED) &&
                 (key_q == key_r);
    exhaust    = !pend_v && !issue_on;
    finish     = ins_take || stop_empty || key_match || exhaust;
    accept     = req_valid && req_ready;
    hash_last  = (hash_step == HASH_LAST_STEP);
    out_free   = !rsp_valid || rsp_ready;
  end

  // remainder by reciprocal: estimate quotient, then subtract it back out
  always_comb begin
    quo_prod  = {{SUM_W{1'b0}}, key_sum} * {{SUM_W{1'b0}}, RECIP};
    back_prod = {{SUM_W{1'b0}}, quo} * {{SUM_W{1'b0}}, TSIZE_SUM};
    rem_sum   = key_sum - back_prod[SUM_W-1:0];
  end

  // shared compare-subtract: remainder correction while hashing, probe step while probing
  always_comb begin
    if (state == ST_HASH) begin
      fold_in = rem;
    end else begin
      fold_in = {1'b0, issue_idx} + {1'b0, inc};
    end
    fold_out = fold(fold_in);
    inc_adv  = fold({1'b0, inc} + (IDX_W + 1)'(2));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_idx == LAST_IDX) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (req.kind == KIND_INSERT || req.kind == KIND_SEARCH ||
              req.kind == KIND_DELETE) begin
            state_next = ST_SUM;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SUM:   state_next = ST_HASH;
      ST_HASH:  if (hash_last) state_next = ST_PROBE;
      ST_PROBE: if (finish) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // memory port controls and handshake
  always_comb begin
    req_ready = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = pend_idx;
    wr_data   = {MARK_USED, key_r};
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_data = {MARK_EMPTY, {KEY_W{1'b0}}};
      end
      ST_IDLE: req_ready = 1'b1;
      ST_PROBE: begin
        rd_en = issue_go;
        if (ins_take) begin
          wr_en = 1'b1;
        end else if (key_match && kind_r == KIND_DELETE) begin
          wr_en   = 1'b1;
          wr_data = {MARK_TOMB, key_r};
        end
      end
      default: ;
    endcase
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[issue_idx];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      issue_on  <= 1'b0;
      pend_v    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (state == ST_HASH && hash_last) begin
        issue_on <= 1'b1;
        pend_v   <= 1'b0;
      end else if (state == ST_PROBE) begin
        pend_v <= issue_go;
        if (issue_on && !issue_go) begin
          issue_on <= 1'b0;
        end
        if (finish) begin
          issue_on <= 1'b0;
          pend_v   <= 1'b0;
        end
      end
      if (state == ST_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          kind_r     <= req.kind;
          key_r      <= norm_key(req.key_chars);
          res_status <= STAT_NOT_FOUND;
          res_idx    <= '0;
        end
      end
      ST_SUM: begin
        key_sum   <= byte_sum(key_r);
        hash_step <= '0;
      end
      ST_HASH: begin
        hash_step <= hash_step + SUM_CNT_W'(1);
        if (hash_step == '0) begin
          quo <= quo_prod[2*SUM_W-1:SUM_W];
        end
        if (hash_step == SUM_CNT_W'(1)) begin
          rem <= (IDX_W + 1)'(rem_sum);
        end
        if (hash_last) begin
          home      <= fold_out;
          issue_idx <= fold_out;
          inc       <= IDX_W'(1);
          first     <= 1'b1;
        end
      end
      ST_PROBE: begin
        if (issue_go) begin
          issue_idx <= fold_out;
          inc       <= inc_adv;
          first     <= 1'b0;
          pend_idx  <= issue_idx;
        end
        if (ins_take || key_match) begin
          res_status <= STAT_DONE;
          res_idx    <= pend_idx;
        end else if (exhaust && kind_r == KIND_INSERT) begin
          res_status <= STAT_FULL;
          res_idx    <= '0;
        end else begin
          res_status <= STAT_NOT_FOUND;
          res_idx    <= '0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          rsp.status <= res_status;
          rsp.slot   <= SLOT_W'(res_idx);
        end
      end
      default: ;
    endcase
  end

  `QPHT_ASSERT_NOW(a_slot_zero_on_fail, rsp_valid && rsp.status != STAT_DONE, rsp.slot == '0, "slot not zero on failed operation")
  `QPHT_ASSERT_NOW(a_pend_follows_read, pend_v, $past(rd_en), "pending probe without a read")
  `QPHT_ASSERT_NOW(a_issue_in_range, issue_on, {1'b0, issue_idx} < TSIZE_EXT, "probe index out of range")
  `QPHT_ASSERT_NEXT(a_write_ends_probe, state == ST_PROBE && wr_en, state == ST_DONE, "probe continued after a write")

endmodule
`default_nettype wire

@@ tb/quadratic_probe_hash_table_unit_tb.sv @@
`default_nettype none
module quadratic_probe_hash_table_unit_tb;
  import qpht_pkg::*;

  localparam int TABLE_SIZE     = 127;
  localparam int KEY_BYTES      = 8;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int POOL_SIZE      = 24;
  localparam int NUM_RANDOM     = 1480;
  localparam int QUIET_AT       = 1300;
  localparam int HOLD_AT        = 400;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_MAX     = 10;

  // Shadow copy of the hash set: predicts each response and checks it in order
  class hash_set_checker;
    logic [MARK_W-1:0] mark [TABLE_SIZE];
    logic [KEY_W-1:0]  stored_key [TABLE_SIZE];
    rsp_item_t         expected_rsp_q [$];
    int unsigned       errors;

    function new();
      errors = 0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        mark[i] = MARK_EMPTY;
        stored_key[i] = '0;
      end
    endfunction

    // Run one operation on the shadow table and return its response
    function rsp_item_t probe_lookup(req_item_t item);
      logic [KEY_W-1:0] key;
      logic [7:0]       ch;
      int unsigned      sum;
      int unsigned      home;
      int unsigned      idx;
      rsp_item_t        r;
      key = '0;
      sum = 0;
      // clear everything from the first NUL byte on
      for (int b = 0; b < KEY_BYTES && b < 8; b++) begin
        ch = item.key_chars[8*b +: 8];
        if (ch == 8'h00) break;
        key[8*b +: 8] = ch;
        sum += 32'(ch);
      end
      home = sum % TABLE_SIZE;
      r.status = STAT_NOT_FOUND;
      r.slot = '0;
      if (item.kind == KIND_UNUSED) return r;
      for (int unsigned c = 0; c <= TABLE_SIZE; c++) begin
        idx = (home + c * c) % TABLE_SIZE;
        // stop once the probe sequence wraps back home
        if (c > 0 && idx == home) break;
        if (item.kind == KIND_INSERT) begin
          if (mark[idx] == MARK_EMPTY) begin
            mark[idx] = MARK_USED;
            stored_key[idx] = key;
            r.status = STAT_DONE;
            r.slot = idx[SLOT_W-1:0];
            return r;
          end
        end else begin
          if (mark[idx] == MARK_EMPTY) break;
          if (mark[idx] == MARK_USED && stored_key[idx] == key) begin
            if (item.kind == KIND_DELETE) mark[idx] = MARK_TOMB;
            r.status = STAT_DONE;
            r.slot = idx[SLOT_W-1:0];
            return r;
          end
        end
      end
      r.status = (item.kind == KIND_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
      return r;
    endfunction

    function void note_request(req_item_t item);
      expected_rsp_q.push_back(probe_lookup(item));
    endfunction

    function void log_mismatch(string msg);
      errors++;
      if (errors <= REPORT_MAX) $display("%s", msg);
    endfunction

    function void check_response(rsp_item_t got);
      rsp_item_t want;
      if (expected_rsp_q.size() == 0) begin
        log_mismatch($sformatf("response with none pending: status=%0d slot=%0d",
                               got.status, got.slot));
        return;
      end
      want = expected_rsp_q.pop_front();
      if (got.status !== want.status || got.slot !== want.slot)
        log_mismatch($sformatf({"response mismatch: expected status=%0d slot=%0d, ",
                                "got status=%0d slot=%0d"},
                               want.status, want.slot, got.status, got.slot));
    endfunction

    function int pending();
      return expected_rsp_q.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  req_item_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  rsp_item_t rsp;

  hash_set_checker table_check = new();

  int req_sent = 0;
  bit quiet = 1'b0;
  bit rsp_holding = 1'b0;

  logic [KEY_W-1:0] pool_key [POOL_SIZE];
  int               pool_len [POOL_SIZE];

  quadratic_probe_hash_table_unit #(
    .TABLE_SIZE(TABLE_SIZE),
    .KEY_BYTES (KEY_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one request, with an occasional idle burst first; return on acceptance
  task automatic offer(input logic [1:0] op, input logic [KEY_W-1:0] key_val);
    if (!quiet && !rsp_holding && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{kind: op, key_chars: key_val};
    do @(posedge clk); while (!req_ready);
    table_check.note_request(req);
    req_sent++;
  endtask

  // Stimulus: directed cases, then a mix of pooled keys and noise
  initial begin
    int               r;
    int               idx;
    int               len;
    int               pos;
    logic [1:0]       op;
    logic [KEY_W-1:0] raw;

    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;

    // build a small key pool; odd entries are byte-reversed twins sharing a home
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_key[i] = '0;
      if (i % 2 == 1) begin
        len = pool_len[i-1];
        for (int b = 0; b < len; b++)
          pool_key[i][8*b +: 8] = pool_key[i-1][8*(len-1-b) +: 8];
      end else begin
        len = $urandom_range(0, 8);
        for (int b = 0; b < len; b++) pool_key[i][8*b +: 8] = 8'($urandom_range(1, 255));
      end
      pool_len[i] = len;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, collisions, tombstones, normalization, unused kind
    offer(KIND_SEARCH, 64'h0);
    offer(KIND_INSERT, 64'h0);
    offer(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    offer(KIND_INSERT, 64'h8080_8080_8080_8080);
    offer(KIND_SEARCH, 64'h8080_8080_8080_8080);
    offer(KIND_INSERT, 64'hA5A5_5AA5_C3C3_0041);
    offer(KIND_INSERT, 64'h0000_0000_0000_0041);
    offer(KIND_DELETE, 64'h0000_0000_0000_0041);
    offer(KIND_SEARCH, 64'hFFFF_FFFF_FFFF_0041);
    offer(KIND_DELETE, 64'h0000_0000_0000_0041);
    offer(KIND_SEARCH, 64'h0000_0000_0000_0041);
    offer(KIND_INSERT, 64'h0000_0000_0000_0041);
    offer(KIND_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    offer(KIND_UNUSED, 64'h0);
    offer(KIND_DELETE, 64'hFFFF_FFFF_FFFF_FF00);
    offer(KIND_SEARCH, 64'h0);
    offer(KIND_DELETE, 64'hFFFF_FFFF_FFFF_FFFF);
    offer(KIND_SEARCH, 64'h0000_0000_0000_007F);
    offer(KIND_INSERT, 64'h0102_0304_0506_0708);
    offer(KIND_SEARCH, 64'h0807_0605_0403_0201);
    offer(KIND_DELETE, 64'h0102_0304_0506_0708);
    offer(KIND_DELETE, 64'h0000_0000_0000_5A5A);

    // random: mostly pooled keys so searches and deletes hit, some raw noise
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (req_sent >= QUIET_AT) quiet = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 10) begin
        op = 2'($urandom_range(0, 3));
        raw = {$urandom, $urandom};
        if ($urandom_range(0, 1)) begin
          pos = $urandom_range(0, 7);
          raw[8*pos +: 8] = 8'h00;
        end
      end else begin
        idx = $urandom_range(0, POOL_SIZE - 1);
        raw = pool_key[idx];
        len = pool_len[idx];
        // junk past the terminator must be ignored
        if (len < 7 && $urandom_range(0, 1))
          for (int b = len + 1; b < 8; b++) raw[8*b +: 8] = 8'($urandom_range(0, 255));
        if (r < 40) op = KIND_INSERT;
        else if (r < 72) op = KIND_SEARCH;
        else op = KIND_DELETE;
      end
      offer(op, raw);
    end
    req_valid <= 1'b0;

    // drain outstanding responses, then let the pipeline settle
    while (table_check.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (table_check.errors == 0 && table_check.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Response side: random stall bursts, one long hold-off to back up the input
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    rsp_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && req_sent >= HOLD_AT) begin
        rsp_holding = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_holding = 1'b0;
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Check every accepted response transaction
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) table_check.check_response(rsp);
    end
  end

  // Abort when no transaction moves for too long
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
